// ----- design/sldf_pkg.sv -----
package sldf_pkg;

  localparam int unsigned BUFFER_DEPTH_DEF = 32;
  localparam logic [7:0]  SYNC_RESET       = 8'h2E;
  localparam int unsigned IDX_W            = 6;

  typedef enum logic [2:0] {
    RD_HEAD,
    RD_CMD,
    RD_LEN,
    RD_PAY,
    RD_CHK
  } rd_sel_e;

  typedef struct packed {
    logic    wr_en;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    drop_one;
    logic    drop_frame;
    logic    ld_cmd;
    logic    ld_len;
    logic    sum_init;
    logic    sum_add;
    logic    idx_clr;
    logic    idx_inc;
    logic    out_load;
  } ctl_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_lt3;
    logic head_match;
    logic len_over;
    logic cnt_lt_total;
    logic idx_eq_len;
    logic chk_ok;
    logic len_zero;
    logic out_done;
    logic out_last;
  } sts_t;

endpackage

// ----- design/sync_length_checksum_deframer_core.sv -----
// First result: raised once the controller has checked the frame's sync byte, command,
// length and checksum and, unless the frame is empty, read its first payload byte; dropped
// bytes, oversize frames and frames with a bad checksum ahead of it delay it further. Each
// later result is read and loaded after the one before is taken. Input: a byte is taken only
// in the idle state, so the rescan controller stalls the input until it returns to idle.
// Reset: asynchronous, active low; clears the store head pointer, the fill count, the controller
// state and the output valid, and sets the sync byte to 0x2E. Store contents are not cleared.
module sync_length_checksum_deframer_core #(
  parameter int unsigned BUFFER_DEPTH = sldf_pkg::BUFFER_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] sync_byte_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] frame_cmd_o,
  output logic [5:0] frame_length_o,
  output logic [7:0] payload_byte_o,
  output logic [5:0] byte_index_o,
  output logic       is_empty_o,
  output logic       last_o
);

  sldf_pkg::ctl_t ctl;
  sldf_pkg::sts_t sts;

  sldf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  sldf_datapath #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .sync_byte_i    (sync_byte_i),
    .rx_byte_i      (rx_byte_i),
    .out_stall_i    (out_stall_i),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .frame_cmd_o    (frame_cmd_o),
    .frame_length_o (frame_length_o),
    .payload_byte_o (payload_byte_o),
    .byte_index_o   (byte_index_o),
    .is_empty_o     (is_empty_o),
    .last_o         (last_o)
  );

endmodule

// ----- design/sldf_datapath.sv -----
module sldf_datapath #(
  parameter int unsigned BUFFER_DEPTH = sldf_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [7:0]              sync_byte_i,
  input  logic [7:0]              rx_byte_i,
  input  logic                    out_stall_i,
  input  sldf_pkg::ctl_t          ctl_i,
  output sldf_pkg::sts_t          sts_o,
  output logic                    out_valid_o,
  output logic [7:0]              frame_cmd_o,
  output logic [5:0]              frame_length_o,
  output logic [7:0]              payload_byte_o,
  output logic [5:0]              byte_index_o,
  output logic                    is_empty_o,
  output logic                    last_o
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned IW = sldf_pkg::IDX_W;

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [AW:0] off);
    logic [AW+1:0] s;
    s = {2'b00, base} + {1'b0, off};
    if (s >= (AW+2)'(BUFFER_DEPTH)) begin
      s = s - (AW+2)'(BUFFER_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  logic [7:0]    mem [BUFFER_DEPTH];

  logic [7:0]    sync_q;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [7:0]    cmd_q, len_q, sum_q;
  logic [IW-1:0] idx_q;
  logic [7:0]    rd_data_q;
  logic          out_valid_q;
  logic [7:0]    frame_cmd_q, payload_q;
  logic [5:0]    frame_length_q, byte_index_q;
  logic          is_empty_q, last_q;

  logic          full;
  logic [AW:0]   wr_off, rd_off, drop_n;
  logic [8:0]    pay_off9, chk_off9, total9;
  logic [AW-1:0] wr_addr, rd_addr;
  logic          len_zero, idx_last;

  assign full     = (count_q == CW'(BUFFER_DEPTH));
  assign wr_off   = full ? '0 : (AW+1)'(count_q);
  assign wr_addr  = wrap_add(head_q, wr_off);
  assign total9   = {1'b0, len_q} + 9'd4;
  assign pay_off9 = 9'(idx_q) + 9'd3;
  assign chk_off9 = {1'b0, len_q} + 9'd3;
  assign len_zero = (len_q == 8'd0);
  assign idx_last = ((8'(idx_q) + 8'd1) == len_q);

  always_comb begin
    case (ctl_i.rd_sel)
      sldf_pkg::RD_HEAD: rd_off = '0;
      sldf_pkg::RD_CMD:  rd_off = (AW+1)'(1);
      sldf_pkg::RD_LEN:  rd_off = (AW+1)'(2);
      sldf_pkg::RD_PAY:  rd_off = pay_off9[AW:0];
      sldf_pkg::RD_CHK:  rd_off = chk_off9[AW:0];
      default:           rd_off = '0;
    endcase
  end

  assign rd_addr = wrap_add(head_q, rd_off);
  assign drop_n  = ctl_i.drop_frame ? total9[AW:0] : (AW+1)'(1);

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (ctl_i.wr_en) begin
      count_d = full ? CW'(1) : count_q + CW'(1);
    end else if (ctl_i.drop_one || ctl_i.drop_frame) begin
      head_d  = wrap_add(head_q, drop_n);
      count_d = count_q - CW'(drop_n);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[wr_addr] <= rx_byte_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q      <= sldf_pkg::SYNC_RESET;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        sync_q <= sync_byte_i;
      end
      head_q  <= head_d;
      count_q <= count_d;
      if (ctl_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_cmd) begin
      cmd_q <= rd_data_q;
    end
    if (ctl_i.ld_len) begin
      len_q <= rd_data_q;
    end
    if (ctl_i.sum_init) begin
      sum_q <= cmd_q + len_q;
    end else if (ctl_i.sum_add) begin
      sum_q <= sum_q + rd_data_q;
    end
    if (ctl_i.idx_clr) begin
      idx_q <= '0;
    end else if (ctl_i.idx_inc) begin
      idx_q <= idx_q + IW'(1);
    end
    if (ctl_i.out_load) begin
      frame_cmd_q    <= cmd_q;
      frame_length_q <= len_q[5:0];
      payload_q      <= len_zero ? 8'd0 : rd_data_q;
      byte_index_q   <= 6'(idx_q);
      is_empty_q     <= len_zero;
      last_q         <= len_zero | idx_last;
    end
  end

  assign sts_o.cnt_zero     = (count_q == '0);
  assign sts_o.cnt_lt3      = (count_q < CW'(3));
  assign sts_o.head_match   = (rd_data_q == sync_q);
  assign sts_o.len_over     = (total9 > 9'(BUFFER_DEPTH));
  assign sts_o.cnt_lt_total = (9'(count_q) < total9);
  assign sts_o.idx_eq_len   = (8'(idx_q) == len_q);
  assign sts_o.chk_ok       = ((~sum_q) == rd_data_q);
  assign sts_o.len_zero     = len_zero;
  assign sts_o.out_done     = out_valid_q & ~out_stall_i;
  assign sts_o.out_last     = last_q;

  assign out_valid_o    = out_valid_q;
  assign frame_cmd_o    = frame_cmd_q;
  assign frame_length_o = frame_length_q;
  assign payload_byte_o = payload_q;
  assign byte_index_o   = byte_index_q;
  assign is_empty_o     = is_empty_q;
  assign last_o         = last_q;

endmodule

// ----- design/sldf_ctrl.sv -----
module sldf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  sldf_pkg::sts_t sts_i,
  output sldf_pkg::ctl_t ctl_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_HEAD_RD,
    S_HEAD_CHK,
    S_CMD,
    S_LEN,
    S_LEN_CHK,
    S_SUM,
    S_SUM_ADD,
    S_CHK,
    S_PAY_RD,
    S_EMIT,
    S_OUT_WAIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.wr_en = 1'b1;
          state_d     = S_HEAD_RD;
        end
      end
      S_HEAD_RD: begin
        if (sts_i.cnt_zero) begin
          state_d = S_IDLE;
        end else begin
          ctl_o.rd_en  = 1'b1;
          ctl_o.rd_sel = sldf_pkg::RD_HEAD;
          state_d      = S_HEAD_CHK;
        end
      end
      S_HEAD_CHK: begin
        if (!sts_i.head_match) begin
          ctl_o.drop_one = 1'b1;
          state_d        = S_HEAD_RD;
        end else if (sts_i.cnt_lt3) begin
          state_d = S_IDLE;
        end else begin
          ctl_o.rd_en  = 1'b1;
          ctl_o.rd_sel = sldf_pkg::RD_CMD;
          state_d      = S_CMD;
        end
      end
      S_CMD: begin
        ctl_o.ld_cmd = 1'b1;
        ctl_o.rd_en  = 1'b1;
        ctl_o.rd_sel = sldf_pkg::RD_LEN;
        state_d      = S_LEN;
      end
      S_LEN: begin
        ctl_o.ld_len = 1'b1;
        state_d      = S_LEN_CHK;
      end
      S_LEN_CHK: begin
        if (sts_i.len_over) begin
          ctl_o.drop_one = 1'b1;
          state_d        = S_HEAD_RD;
        end else if (sts_i.cnt_lt_total) begin
          state_d = S_IDLE;
        end else begin
          ctl_o.sum_init = 1'b1;
          ctl_o.idx_clr  = 1'b1;
          state_d        = S_SUM;
        end
      end
      S_SUM: begin
        ctl_o.rd_en = 1'b1;
        if (sts_i.idx_eq_len) begin
          ctl_o.rd_sel = sldf_pkg::RD_CHK;
          state_d      = S_CHK;
        end else begin
          ctl_o.rd_sel = sldf_pkg::RD_PAY;
          state_d      = S_SUM_ADD;
        end
      end
      S_SUM_ADD: begin
        ctl_o.sum_add = 1'b1;
        ctl_o.idx_inc = 1'b1;
        state_d       = S_SUM;
      end
      S_CHK: begin
        if (!sts_i.chk_ok) begin
          ctl_o.drop_one = 1'b1;
          state_d        = S_HEAD_RD;
        end else begin
          ctl_o.idx_clr = 1'b1;
          state_d       = sts_i.len_zero ? S_EMIT : S_PAY_RD;
        end
      end
      S_PAY_RD: begin
        ctl_o.rd_en  = 1'b1;
        ctl_o.rd_sel = sldf_pkg::RD_PAY;
        state_d      = S_EMIT;
      end
      S_EMIT: begin
        ctl_o.out_load = 1'b1;
        state_d        = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (sts_i.out_done) begin
          if (sts_i.out_last) begin
            ctl_o.drop_frame = 1'b1;
            state_d          = S_HEAD_RD;
          end else begin
            ctl_o.idx_inc = 1'b1;
            state_d       = S_PAY_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule
